/* rtl/rbdq_pkg.sv */
`timescale 1ns / 1ps

package rbdq_pkg;

  // Command codes carried in the command field of an input beat.
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_QUERY      = 3'd4;

  // Status codes returned with every result beat.
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // What one chain of cells does in a cycle.
  typedef enum logic [1:0] {
    CH_HOLD,   // every cell keeps its word
    CH_PUSH,   // words move one cell away from cell 0, cell 0 takes the new word
    CH_POP,    // words move one cell toward cell 0
    CH_WRITE   // the cell whose position equals the count takes the new word
  } chain_op_t;

  // Control broadcast to every cell, one operation per chain.
  typedef struct packed {
    chain_op_t f_op;
    chain_op_t b_op;
  } cell_ctl_t;

endpackage

/* rtl/rbdq_if.sv */
`timescale 1ns / 1ps

// Command channel: one beat is one deque command.
interface rbdq_cmd_if #(
  parameter int DATA_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [2:0]            command;
  logic [DATA_WIDTH-1:0] data_in;

  modport source (output valid, output command, output data_in, input ready);
  modport sink   (input valid, input command, input data_in, output ready);
endinterface

// Result channel: one beat per command.
interface rbdq_rsp_if #(
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 5
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [CNT_W-1:0]      element_count;
  logic [DATA_WIDTH-1:0] front_word;
  logic [DATA_WIDTH-1:0] back_word;
  logic                  words_valid;

  modport source (output valid, output status, output element_count, output front_word,
                  output back_word, output words_valid, input ready);
  modport sink   (input valid, input status, input element_count, input front_word,
                  input back_word, input words_valid, output ready);
endinterface

/* rtl/ring_buffer_deque_top.sv */
`timescale 1ns / 1ps

// Double-ended queue of up to DEPTH words of DATA_WIDTH bits. Each command beat
// (push front, push back, pop front, pop back, or query; unused codes act as a
// query) yields exactly one result beat that carries the status, the element
// count and the front and back words as they stand after the command. A push into
// a full queue is rejected with status 1 and a pop on an empty queue is ignored
// with status 2; neither changes the contents. The queue is a row of DEPTH cells
// holding two copies of the contents: one chain ordered from the front and one
// ordered from the back, so both end words always sit in cell 0. For a command,
// every cell moves or writes its words in the same edge, and the result is
// captured in an output register, so a new command is taken in every cycle in
// which the result register is empty or being drained. Results appear in the
// cycle after the command beat. There is no clearing pass after reset.
module ring_buffer_deque_top
  import rbdq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input logic        clk,
  input logic        rst,
  rbdq_cmd_if.sink   cmd,
  rbdq_rsp_if.source rsp
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic                  accept;
  logic                  full;
  logic                  empty;
  logic [1:0]            status_next;
  cell_ctl_t             ctl;

  logic [DATA_WIDTH-1:0] f_q    [DEPTH];
  logic [DATA_WIDTH-1:0] b_q    [DEPTH];
  logic [DATA_WIDTH-1:0] f_next [DEPTH];
  logic [DATA_WIDTH-1:0] b_next [DEPTH];

  // The result register parts the two sides: a command is taken whenever the
  // held result is absent or leaves in this same cycle.
  assign cmd.ready = !rsp.valid || rsp.ready;
  assign accept    = cmd.valid && cmd.ready;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);

  // Decode the command into one operation per chain. Pushing at one end shifts
  // that end's chain and writes the word at the far end of the other chain,
  // which is the position given by the current count. Popping at one end shifts
  // that end's chain; the other chain simply forgets its last live word.
  always_comb begin
    ctl.f_op    = CH_HOLD;
    ctl.b_op    = CH_HOLD;
    status_next = ST_DONE;
    count_next  = count;
    if (accept) begin
      case (cmd.command)
        CMD_PUSH_FRONT: begin
          if (full) begin
            status_next = ST_FULL;
          end else begin
            ctl.f_op   = CH_PUSH;
            ctl.b_op   = CH_WRITE;
            count_next = count + CNT_W'(1);
          end
        end
        CMD_PUSH_BACK: begin
          if (full) begin
            status_next = ST_FULL;
          end else begin
            ctl.f_op   = CH_WRITE;
            ctl.b_op   = CH_PUSH;
            count_next = count + CNT_W'(1);
          end
        end
        CMD_POP_FRONT: begin
          if (empty) begin
            status_next = ST_EMPTY;
          end else begin
            ctl.f_op   = CH_POP;
            count_next = count - CNT_W'(1);
          end
        end
        CMD_POP_BACK: begin
          if (empty) begin
            status_next = ST_EMPTY;
          end else begin
            ctl.b_op   = CH_POP;
            count_next = count - CNT_W'(1);
          end
        end
        default: begin
          // Query and unused codes leave everything as it is.
        end
      endcase
    end
  end

  // Row of cells. Cell 0 takes the pushed word from the command beat; the last
  // cell has no upper neighbor, and what it pulls in on a pop lies past the
  // live contents, so it never reaches a result.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] f_lo;
    logic [DATA_WIDTH-1:0] b_lo;
    logic [DATA_WIDTH-1:0] f_hi;
    logic [DATA_WIDTH-1:0] b_hi;

    if (i == 0) begin : g_first
      assign f_lo = cmd.data_in;
      assign b_lo = cmd.data_in;
    end else begin : g_mid_lo
      assign f_lo = f_q[i-1];
      assign b_lo = b_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign f_hi = '0;
      assign b_hi = '0;
    end else begin : g_mid_hi
      assign f_hi = f_q[i+1];
      assign b_hi = b_q[i+1];
    end

    rbdq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .IDX        (i)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .count   (count),
      .data_in (cmd.data_in),
      .f_lo    (f_lo),
      .f_hi    (f_hi),
      .b_lo    (b_lo),
      .b_hi    (b_hi),
      .f_q     (f_q[i]),
      .b_q     (b_q[i]),
      .f_next  (f_next[i]),
      .b_next  (b_next[i])
    );
  end

  // Element count and result valid are control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Result payload. The end words come from cell 0 of each chain as they will
  // stand after this edge; an empty queue reports zero words.
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status        <= status_next;
      rsp.element_count <= count_next;
      rsp.words_valid   <= (count_next != '0);
      rsp.front_word    <= (count_next != '0) ? f_next[0] : '0;
      rsp.back_word     <= (count_next != '0) ? b_next[0] : '0;
    end
  end

endmodule

/* rtl/rbdq_cell.sv */
`timescale 1ns / 1ps

// One position of the two element chains. The front-ordered word sits at
// distance IDX from the front, the back-ordered word at distance IDX from the back.
module rbdq_cell
  import rbdq_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 5,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic [CNT_W-1:0]      count,
  input  logic [DATA_WIDTH-1:0] data_in,
  input  logic [DATA_WIDTH-1:0] f_lo,
  input  logic [DATA_WIDTH-1:0] f_hi,
  input  logic [DATA_WIDTH-1:0] b_lo,
  input  logic [DATA_WIDTH-1:0] b_hi,
  output logic [DATA_WIDTH-1:0] f_q,
  output logic [DATA_WIDTH-1:0] b_q,
  output logic [DATA_WIDTH-1:0] f_next,
  output logic [DATA_WIDTH-1:0] b_next
);

  logic at_count;

  assign at_count = (count == CNT_W'(IDX));

  always_comb begin
    case (ctl.f_op)
      CH_PUSH:  f_next = f_lo;
      CH_POP:   f_next = f_hi;
      CH_WRITE: f_next = at_count ? data_in : f_q;
      default:  f_next = f_q;
    endcase
    case (ctl.b_op)
      CH_PUSH:  b_next = b_lo;
      CH_POP:   b_next = b_hi;
      CH_WRITE: b_next = at_count ? data_in : b_q;
      default:  b_next = b_q;
    endcase
  end

  always_ff @(posedge clk) begin
    f_q <= f_next;
    b_q <= b_next;
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import rbdq_pkg::*;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = IDX_W + 1;

  // Command codes that the block does not define. They must behave like a query.
  localparam logic [2:0] CMD_SPARE_5 = 3'd5;
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  // Run shape. The calm tail is the closing stretch of random beats in which
  // neither side idles, so the block runs at full rate to the end.
  localparam int RANDOM_BEATS  = 1250;
  localparam int CALM_TAIL     = 150;
  localparam int LONG_HOLD     = 60;
  localparam int STUCK_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;

  // One result beat, field for field as the result channel carries it.
  typedef struct packed {
    logic [1:0]            status;
    logic [CNT_W-1:0]      element_count;
    logic [DATA_WIDTH-1:0] front_word;
    logic [DATA_WIDTH-1:0] back_word;
    logic                  words_valid;
  } deque_reply_t;

  // Software copy of the deque. Every accepted command is applied here at once
  // and the reply that the block owes for it is queued; replies from the block
  // are then matched against that queue in order.
  class deque_shadow;
    logic [DATA_WIDTH-1:0] words [DEPTH];
    logic [IDX_W-1:0]      head;
    logic [CNT_W-1:0]      fill;
    deque_reply_t          awaited[$];
    int unsigned           mismatches;

    function new();
      head       = '0;
      fill       = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void apply_command(logic [2:0] op, logic [DATA_WIDTH-1:0] word);
      deque_reply_t     reply;
      logic [IDX_W-1:0] slot;
      reply = '0;
      reply.status = ST_DONE;
      case (op)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (fill == CNT_W'(DEPTH)) begin
            reply.status = ST_FULL;
          end else begin
            if (op == CMD_PUSH_FRONT) begin
              head = head - IDX_W'(1);
              words[head] = word;
            end else begin
              slot = head + fill[IDX_W-1:0];
              words[slot] = word;
            end
            fill = fill + CNT_W'(1);
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK: begin
          if (fill == '0) begin
            reply.status = ST_EMPTY;
          end else begin
            fill = fill - CNT_W'(1);
            if (op == CMD_POP_FRONT) head = head + IDX_W'(1);
          end
        end
        default: ;
      endcase
      reply.element_count = fill;
      if (fill != '0) begin
        // With a full store the low index bits of fill are zero, so the back
        // slot still lands one below the head.
        slot = head + fill[IDX_W-1:0] - IDX_W'(1);
        reply.front_word  = words[head];
        reply.back_word   = words[slot];
        reply.words_valid = 1'b1;
      end
      awaited.push_back(reply);
    endfunction

    function void check_field(string field, logic [DATA_WIDTH-1:0] want,
                              logic [DATA_WIDTH-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void compare_reply(deque_reply_t seen);
      deque_reply_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result beat with no command outstanding, expected none, actual 'h%0h",
                 $time, seen);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      check_field("status", DATA_WIDTH'(want.status), DATA_WIDTH'(seen.status));
      check_field("element_count", DATA_WIDTH'(want.element_count),
                  DATA_WIDTH'(seen.element_count));
      check_field("front_word", want.front_word, seen.front_word);
      check_field("back_word", want.back_word, seen.back_word);
      check_field("words_valid", DATA_WIDTH'(want.words_valid),
                  DATA_WIDTH'(seen.words_valid));
    endfunction
  endclass

  logic clk;
  logic rst;

  rbdq_cmd_if #(.DATA_WIDTH(DATA_WIDTH)) cmd_if ();
  rbdq_rsp_if #(.DATA_WIDTH(DATA_WIDTH), .CNT_W(CNT_W)) rsp_if ();

  ring_buffer_deque_top #(
    .DEPTH(DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .rsp(rsp_if)
  );

  deque_shadow shadow = new();

  // Set by the command side to ask the result side for one long hold-off.
  bit hold_off_req;
  // High during the closing stretch: no idling on either side.
  bit calm;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Drive one command beat and return at the edge where it is taken. The
  // valid stays high on return so back-to-back beats need no second update.
  task automatic send_beat(input logic [2:0] op, input logic [DATA_WIDTH-1:0] word);
    cmd_if.valid   <= 1'b1;
    cmd_if.command <= op;
    cmd_if.data_in <= word;
    do @(posedge clk); while (cmd_if.ready !== 1'b1);
  endtask

  task automatic idle_source(input int cycles);
    cmd_if.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stop offering commands until every reply owed so far has come back.
  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    do @(posedge clk); while (shadow.pending() != 0);
  endtask

  // Command side: reset, a directed opening, then random segments, each with
  // its own bias between pushes and pops so that the queue swings between
  // empty and full many times over the run.
  initial begin : source_side
    int                    sent;
    int                    seg_left;
    int                    push_pct;
    int                    gap_pct;
    int                    roll;
    logic [2:0]            op;
    logic [DATA_WIDTH-1:0] word;

    cmd_if.valid   <= 1'b0;
    cmd_if.command <= CMD_QUERY;
    cmd_if.data_in <= '0;
    rst            <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Pops and queries on the empty queue, including the undefined codes.
    send_beat(CMD_POP_FRONT, 32'hDEAD_BEEF);
    send_beat(CMD_POP_BACK, 32'h0000_0001);
    send_beat(CMD_QUERY, '1);
    send_beat(CMD_SPARE_5, 32'h8000_0000);
    send_beat(CMD_SPARE_6, '0);
    send_beat(CMD_SPARE_7, '1);
    // Extreme words through both ends, then back to empty from both ends.
    send_beat(CMD_PUSH_FRONT, '0);
    send_beat(CMD_PUSH_BACK, '1);
    send_beat(CMD_POP_FRONT, '0);
    send_beat(CMD_POP_BACK, '0);
    // Fill from both ends so the head index wraps below zero, then push
    // into the full queue at each end.
    for (int i = 0; i < DEPTH; i++) begin
      send_beat(i[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, {8{i[3:0]}} ^ 32'hA5A5_0F0F);
    end
    send_beat(CMD_PUSH_FRONT, 32'h1234_5678);
    send_beat(CMD_PUSH_BACK, 32'h8765_4321);

    sent     = 0;
    seg_left = 0;
    push_pct = 50;
    gap_pct  = 0;
    while (sent < RANDOM_BEATS) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(8, 60);
        case ($urandom_range(0, 3))
          0:       push_pct = 85;
          1:       push_pct = 15;
          default: push_pct = $urandom_range(35, 65);
        endcase
        // A third of the segments run without gaps on this side.
        gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      end
      seg_left--;

      // Twice the result side holds off for a long stretch while commands
      // keep coming, and twice this side waits for the queue of owed
      // replies to run dry.
      if (sent == 300 || sent == 850) hold_off_req = 1'b1;
      if (sent == 550 || sent == 1000) wait_drained();
      calm = (sent >= RANDOM_BEATS - CALM_TAIL);

      roll = $urandom_range(0, 99);
      word = ($urandom_range(0, 15) == 0) ? {DATA_WIDTH{roll[0]}} : DATA_WIDTH'($urandom);
      if (roll < 5) begin
        case (roll)
          0, 1:    op = CMD_QUERY;
          2:       op = CMD_SPARE_5;
          3:       op = CMD_SPARE_6;
          default: op = CMD_SPARE_7;
        endcase
      end else if ($urandom_range(0, 99) < push_pct) begin
        op = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      end else begin
        op = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
      end
      send_beat(op, word);
      sent++;

      if (!calm && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
        idle_source($urandom_range(1, 9));
      end
    end

    // Let the last replies drain, then wait out the settling period so that the
    // block can show any beat that it should not send.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("** ring_buffer_deque_top: PASSED **");
    end else begin
      $display("** ring_buffer_deque_top: FAILED **");
    end
    $finish;
  end

  // Result side: ready is set once per pass of the loop and then held for a
  // random span. Short stalls come in random bursts; a requested hold-off is
  // counted here so that the block fills and stalls its input.
  initial begin : sink_side
    int span;
    rsp_if.ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rsp_if.ready <= 1'b0;
        span = LONG_HOLD;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        rsp_if.ready <= 1'b0;
        span = $urandom_range(1, 9);
      end else begin
        rsp_if.ready <= 1'b1;
        span = $urandom_range(1, 24);
      end
      repeat (span) @(posedge clk);
    end
  end

  // Both channels are sampled at the clock edge, before any update made at
  // that edge, so the block's registered outputs and the driven inputs are
  // seen as they stood during the cycle. The watchdog counts cycles in which
  // no beat moves on either channel.
  int unsigned stuck_cycles;

  always @(posedge clk) begin : monitor
    deque_reply_t seen;
    if (!rst && cmd_if.valid && cmd_if.ready) begin
      shadow.apply_command(cmd_if.command, cmd_if.data_in);
    end
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      seen.status        = rsp_if.status;
      seen.element_count = rsp_if.element_count;
      seen.front_word    = rsp_if.front_word;
      seen.back_word     = rsp_if.back_word;
      seen.words_valid   = rsp_if.words_valid;
      shadow.compare_reply(seen);
    end
    if (rst || (cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, stuck_cycles);
      $display("** ring_buffer_deque_top: FAILED **");
      $finish;
    end
  end

endmodule

/* ring_buffer_deque_top.f */
rtl/rbdq_pkg.sv
rtl/rbdq_if.sv
rtl/rbdq_cell.sv
rtl/ring_buffer_deque_top.sv
tb/sv/testbench.sv
